[hdl/pbd_pkg.sv]
`timescale 1ns / 1ps
package pbd_pkg;

  // Field widths
  localparam int ANGLE_W   = 16;
  localparam int ERR_W     = ANGLE_W + 1;
  localparam int DT_W      = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 23;
  localparam int DBAND_W   = 8;
  localparam int ACC_W     = 24;
  localparam int DRIVE_W   = 24;
  localparam int PWM_W     = 8;

  // Serial datapath widths
  localparam int SUM_W     = 46;  // weighted sum, 20 fraction bits
  localparam int FRAC_W    = 20;
  localparam int PROD_W    = 32;  // |error * dt|
  localparam int DDIV_W    = 27;  // |angle delta| * 1000
  localparam int DERIV_W   = DDIV_W + 1;
  localparam int CLAMP_W   = ACC_W + 1;

  localparam logic [DT_W-1:0]  MS_PER_S = DT_W'(1000);
  localparam logic [PWM_W-1:0] PWM_MAX  = 8'd255;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT       = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_GAIN_D         = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_DEAD_BAND      = 3'd5
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'h7FFFFF;
  localparam logic [DBAND_W-1:0] DBAND_RESET = 8'd5;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [DT_W-1:0]           dt_ms;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      forward;
    logic [PWM_W-1:0]          pwm_duty;
  } result_t;

  // Command into the serial multiply-accumulate unit
  typedef struct packed {
    logic load;       // take a new multiplicand / multiplier pair
    logic clear_acc;  // start a fresh sum with this pair
  } mac_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_QUOT,
    S_INTEG,
    S_MACP,
    S_MACI,
    S_MACD,
    S_DONE
  } state_t;

endpackage

[hdl/pbd_div.sv]
`timescale 1ns / 1ps
module pbd_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          busy
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] count;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // One restoring step: bring down the next dividend bit
  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  assign busy     = (count != '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(NW);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Dividend shifts out the top as quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

[hdl/pbd_mac.sv]
`timescale 1ns / 1ps
module pbd_mac #(
  parameter int AW = 46,
  parameter int MW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbd_pkg::mac_cmd_t    cmd,
  input  logic signed [AW-1:0] mcand,
  input  logic [MW-1:0]        mplier,
  output logic signed [AW-1:0] acc,
  output logic                 busy
);

  import pbd_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [CW-1:0]        count;
  logic signed [AW-1:0] mcand_sh;
  logic [MW-1:0]        mplier_sh;

  assign busy = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= CW'(MW);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Shift-add: one multiplier bit per cycle, LSB first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mcand_sh  <= mcand;
      mplier_sh <= mplier;
      if (cmd.clear_acc) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mplier_sh[0]) begin
        acc <= acc + mcand_sh;
      end
      mcand_sh  <= mcand_sh <<< 1;
      mplier_sh <= mplier_sh >> 1;
    end
  end

endmodule

[hdl/pid_balance_drive.sv]
`timescale 1ns / 1ps
// Each sample with a nonzero dt_ms runs through the bit-serial multiplier (four products)
// and the 32-step divider for the integral increment; a zero dt_ms skips the arithmetic.
// A new sample is taken only after the previous result has been placed in the output register.
// Reset (rst, synchronous) restores register defaults and clears the integral and angle.
module pid_balance_drive (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  pbd_pkg::sample_t                    sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output pbd_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import pbd_pkg::*;

  // Configuration registers
  logic signed [ANGLE_W-1:0] setpoint;
  logic [GAIN_W-1:0]         gain_p;
  logic [GAIN_W-1:0]         gain_i;
  logic [GAIN_W-1:0]         gain_d;
  logic [LIMIT_W-1:0]        integral_limit;
  logic [DBAND_W-1:0]        dead_band;

  // Controller state
  logic signed [ACC_W-1:0]   integral_acc;
  logic signed [ANGLE_W-1:0] previous_angle;
  state_t                    state;
  state_t                    state_next;

  // Per-transaction registers
  logic signed [ERR_W-1:0]   error_r;
  logic signed [ANGLE_W-1:0] angle_r;
  logic                      zero_dt;
  logic                      deriv_neg;

  logic accept;
  logic out_free;

  // Serial unit hookup
  mac_cmd_t                  mac_cmd;
  logic signed [SUM_W-1:0]   mac_mcand;
  logic [GAIN_W-1:0]         mac_mplier;
  logic signed [SUM_W-1:0]   mac_acc;
  logic                      mac_busy;
  logic                      div_i_start;
  logic                      div_d_start;
  logic [PROD_W-1:0]         div_i_q;
  logic [DDIV_W-1:0]         div_d_q;
  logic                      div_i_busy;
  logic                      div_d_busy;

  // Front-end arithmetic on the incoming sample
  logic signed [ERR_W-1:0]   err_in;
  logic signed [ERR_W-1:0]   diff_in;
  logic [ERR_W-1:0]          diff_mag;
  logic [DDIV_W-1:0]         diff_ext;
  logic [DDIV_W-1:0]         diff_x1000;

  // Integral update
  logic [SUM_W-1:0]          prod_mag;
  logic [LIMIT_W-1:0]        inc_mag;
  logic signed [CLAMP_W-1:0] inc;
  logic signed [CLAMP_W-1:0] integ_sum;
  logic signed [CLAMP_W-1:0] lim_pos;
  logic signed [CLAMP_W-1:0] lim_neg;
  logic signed [CLAMP_W-1:0] integ_clamped;

  // Derivative term
  logic signed [DERIV_W-1:0] deriv;

  // Drive stage
  logic                      sum_neg;
  logic [SUM_W-1:0]          sum_mag;
  logic [SUM_W-FRAC_W-1:0]   sum_int;
  logic [DRIVE_W-1:0]        drive_mag;
  logic                      in_dead;
  result_t                   result_calc;

  assign accept    = sample_valid && sample_ready;
  assign out_free  = !result_valid || result_ready;
  assign cfg_ready = 1'b1;

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= LIMIT_RESET;
      dead_band      <= DBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:       setpoint       <= cfg_data[ANGLE_W-1:0];
        REG_GAIN_P:         gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:         gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:         gain_d         <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_DEAD_BAND:      dead_band      <= cfg_data[DBAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Error and scaled angle delta
  always_comb begin
    err_in     = {setpoint[ANGLE_W-1], setpoint}
               - {sample.angle[ANGLE_W-1], sample.angle};
    diff_in    = {sample.angle[ANGLE_W-1], sample.angle}
               - {previous_angle[ANGLE_W-1], previous_angle};
    diff_mag   = diff_in[ERR_W-1] ? ERR_W'(-diff_in) : diff_in;
    diff_ext   = DDIV_W'(diff_mag);
    // x * 1000 = x * 1024 - x * 16 - x * 8
    diff_x1000 = (diff_ext << 10) - (diff_ext << 4) - (diff_ext << 3);
  end

  // Integral: trunc0(error * dt / 1000) added, then clamped
  always_comb begin
    prod_mag  = mac_acc[SUM_W-1] ? SUM_W'(-mac_acc) : SUM_W'(mac_acc);
    inc_mag   = div_i_q[LIMIT_W-1:0];
    inc       = error_r[ERR_W-1] ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
    integ_sum = {integral_acc[ACC_W-1], integral_acc} + inc;
    lim_pos   = $signed({2'b00, integral_limit});
    lim_neg   = -lim_pos;
    if (integ_sum > lim_pos) begin
      integ_clamped = lim_pos;
    end else if (integ_sum < lim_neg) begin
      integ_clamped = lim_neg;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  assign deriv = deriv_neg ? -$signed({1'b0, div_d_q}) : $signed({1'b0, div_d_q});

  // Drive: drop fraction toward zero, saturate, deadband (zero dt_ms also gives zero), PWM clamp
  always_comb begin
    sum_neg = mac_acc[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-mac_acc) : SUM_W'(mac_acc);
    sum_int = sum_mag[SUM_W-1:FRAC_W];
    if (sum_neg) begin
      drive_mag = (sum_int > (SUM_W-FRAC_W)'(24'h800000)) ? 24'h800000
                                                          : sum_int[DRIVE_W-1:0];
    end else begin
      drive_mag = (sum_int > (SUM_W-FRAC_W)'(24'h7FFFFF)) ? 24'h7FFFFF
                                                          : sum_int[DRIVE_W-1:0];
    end
    in_dead = zero_dt || (drive_mag < DRIVE_W'(dead_band));
    if (in_dead) begin
      result_calc.drive    = '0;
      result_calc.forward  = 1'b0;
      result_calc.pwm_duty = '0;
    end else begin
      result_calc.drive    = sum_neg ? -$signed(drive_mag) : $signed(drive_mag);
      // a zero drive is not forward
      result_calc.forward  = !sum_neg && (drive_mag != '0);
      result_calc.pwm_duty = (drive_mag > DRIVE_W'(PWM_MAX)) ? PWM_MAX
                                                             : drive_mag[PWM_W-1:0];
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = (sample.dt_ms == '0) ? S_DONE : S_PROD;
      S_PROD:  if (!mac_busy) state_next = S_QUOT;
      S_QUOT:  if (!div_i_busy && !div_d_busy) state_next = S_INTEG;
      S_INTEG: state_next = S_MACP;
      S_MACP:  if (!mac_busy) state_next = S_MACI;
      S_MACI:  if (!mac_busy) state_next = S_MACD;
      S_MACD:  if (!mac_busy) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: unit commands
  always_comb begin
    sample_ready  = 1'b0;
    mac_cmd       = '0;
    mac_mcand     = '0;
    mac_mplier    = '0;
    div_i_start   = 1'b0;
    div_d_start   = 1'b0;
    case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (accept && (sample.dt_ms != '0)) begin
          mac_cmd.load      = 1'b1;
          mac_cmd.clear_acc = 1'b1;
          mac_mcand         = SUM_W'(err_in);
          mac_mplier        = sample.dt_ms;
          div_d_start       = 1'b1;
        end
      end
      S_PROD: begin
        div_i_start = !mac_busy;
      end
      S_INTEG: begin
        mac_cmd.load      = 1'b1;
        mac_cmd.clear_acc = 1'b1;
        mac_mcand         = SUM_W'(error_r);
        mac_mplier        = gain_p;
      end
      S_MACP: begin
        mac_cmd.load = !mac_busy;
        mac_mcand    = SUM_W'(integral_acc);
        mac_mplier   = gain_i;
      end
      S_MACI: begin
        mac_cmd.load = !mac_busy;
        mac_mcand    = SUM_W'(deriv);
        mac_mplier   = gain_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      error_r   <= err_in;
      angle_r   <= sample.angle;
      zero_dt   <= (sample.dt_ms == '0);
      deriv_neg <= diff_in[ERR_W-1];
    end
  end

  // Controller state update
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc   <= '0;
      previous_angle <= '0;
    end else if (state == S_INTEG) begin
      integral_acc   <= integ_clamped[ACC_W-1:0];
      previous_angle <= angle_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      result <= result_calc;
    end
  end

  pbd_mac #(
    .AW (SUM_W),
    .MW (GAIN_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mac_cmd),
    .mcand  (mac_mcand),
    .mplier (mac_mplier),
    .acc    (mac_acc),
    .busy   (mac_busy)
  );

  // Integral increment: |error * dt| / 1000
  pbd_div #(
    .NW (PROD_W),
    .DW (DT_W)
  ) u_div_i (
    .clk      (clk),
    .rst      (rst),
    .start    (div_i_start),
    .dividend (prod_mag[PROD_W-1:0]),
    .divisor  (MS_PER_S),
    .quotient (div_i_q),
    .busy     (div_i_busy)
  );

  // Derivative: |angle delta| * 1000 / dt
  pbd_div #(
    .NW (DDIV_W),
    .DW (DT_W)
  ) u_div_d (
    .clk      (clk),
    .rst      (rst),
    .start    (div_d_start),
    .dividend (diff_x1000),
    .divisor  (sample.dt_ms),
    .quotient (div_d_q),
    .busy     (div_d_busy)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
import pbd_pkg::*;

// Shadow of the controller: register copies, integral and last angle, plus the
// queue of drive results the block still owes.
class drive_scoreboard;
  localparam longint MS_PER_SEC = 1000;
  localparam longint DRIVE_HI   = 8388607;
  localparam longint DRIVE_LO   = -8388608;

  longint target, kp, ki, kd, limit, dband;
  longint integ, last_angle;
  result_t drive_due[$];
  int n_samples, n_checked, n_bad;
  int n_zero_dt, n_dead, n_iclamp, n_sat, n_duty_top;

  function new();
    target = 0;
    kp = 0;
    ki = 0;
    kd = 0;
    limit = LIMIT_RESET;
    dband = DBAND_RESET;
    integ = 0;
    last_angle = 0;
  endfunction

  // Register write transaction; unused indexes fall through
  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SETPOINT:       target = longint'($signed(data[ANGLE_W-1:0]));
      REG_GAIN_P:         kp = data[GAIN_W-1:0];
      REG_GAIN_I:         ki = data[GAIN_W-1:0];
      REG_GAIN_D:         kd = data[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT: limit = data[LIMIT_W-1:0];
      REG_DEAD_BAND:      dband = data[DBAND_W-1:0];
      default: ;
    endcase
  endfunction

  // Accepted sample: step the PID state and queue the drive it must produce
  function void take_sample(sample_t s);
    longint ang, dt, err, inc, deriv, acc, sum, drv, mag;
    result_t r;
    ang = longint'($signed(s.angle));
    dt = longint'(s.dt_ms);
    drv = 0;
    n_samples++;
    if (dt == 0) begin
      n_zero_dt++;
    end else begin
      err = target - ang;
      inc = (err * dt) / MS_PER_SEC;
      deriv = ((ang - last_angle) * MS_PER_SEC) / dt;
      acc = integ + inc;
      if (acc > limit || acc < -limit) n_iclamp++;
      integ = (acc > limit) ? limit : (acc < -limit) ? -limit : acc;
      last_angle = ang;
      sum = err * kp + integ * ki + deriv * kd;
      // drop the fraction bits toward zero
      drv = (sum < 0) ? -((-sum) >>> FRAC_W) : (sum >>> FRAC_W);
      if (drv > DRIVE_HI || drv < DRIVE_LO) n_sat++;
      drv = (drv > DRIVE_HI) ? DRIVE_HI : (drv < DRIVE_LO) ? DRIVE_LO : drv;
      mag = (drv < 0) ? -drv : drv;
      if (mag < dband) begin
        if (mag != 0) n_dead++;
        drv = 0;
      end
    end
    mag = (drv < 0) ? -drv : drv;
    if (mag >= longint'(PWM_MAX)) n_duty_top++;
    r.drive = drv[DRIVE_W-1:0];
    r.forward = (drv > 0);
    r.pwm_duty = (mag > longint'(PWM_MAX)) ? PWM_MAX : mag[PWM_W-1:0];
    drive_due.push_back(r);
  endfunction

  // Accepted result transaction against the oldest expectation
  function void check_drive(result_t got);
    result_t want;
    if (drive_due.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("ERROR: result with none expected: drive=%0d forward=%0d pwm=%0d",
                 got.drive, got.forward, got.pwm_duty);
      return;
    end
    want = drive_due.pop_front();
    n_checked++;
    if (got.drive !== want.drive || got.forward !== want.forward ||
        got.pwm_duty !== want.pwm_duty) begin
      n_bad++;
      if (n_bad <= 10)
        $display("ERROR: result %0d: expected drive=%0d forward=%0d pwm=%0d, got drive=%0d forward=%0d pwm=%0d",
                 n_checked, want.drive, want.forward, want.pwm_duty,
                 got.drive, got.forward, got.pwm_duty);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int TAIL_CYCLES = 250;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_scoreboard book = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic want_hold = 1'b0;
  logic hold_used = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int n_loads = 0;
  int cur_target = 0;
  int walk_angle = 0;

  pid_balance_drive dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycles, book.drive_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each transaction, random backpressure, one long hold
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) book.check_drive(result);
      if (want_hold && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        result_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // One sample transaction; valid stays up if the next one follows at once
  task automatic send_sample(input logic signed [ANGLE_W-1:0] ang,
                             input logic [DT_W-1:0] dt);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sample_valid <= 1'b1;
    sample <= '{angle: ang, dt_ms: dt};
    do @(posedge clk); while (!sample_ready);
    book.take_sample(sample);
  endtask

  // Stop offering samples and wait for every owed result
  task automatic drain();
    sample_valid <= 1'b0;
    while (book.drive_due.size() != 0) @(posedge clk);
  endtask

  // Register write; bits above the register width carry junk
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int w,
                           input longint val);
    logic [CFG_DATA_W-1:0] mask, data;
    mask = CFG_DATA_W'((longint'(1) << w) - 1);
    data = (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    book.write_reg(idx, data);
  endtask

  // Full register set, only with the block idle; spare indexes must be ignored
  task automatic load_regs(input longint tgt, gp, gi, gd, lim, db);
    drain();
    write_reg(REG_SETPOINT, ANGLE_W, tgt);
    write_reg(REG_GAIN_P, GAIN_W, gp);
    write_reg(REG_GAIN_I, GAIN_W, gi);
    write_reg(REG_GAIN_D, GAIN_W, gd);
    write_reg(REG_INTEGRAL_LIMIT, LIMIT_W, lim);
    write_reg(REG_DEAD_BAND, DBAND_W, db);
    write_reg(REG_SPARE_LO, CFG_DATA_W, longint'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W, longint'($urandom));
    cfg_valid <= 1'b0;
    cur_target = int'(tgt);
    walk_angle = int'(tgt);
    n_loads++;
  endtask

  function automatic longint pick_gain();
    if ($urandom_range(1) == 0) return longint'($urandom_range(0, 1023));
    return longint'($urandom_range(0, 65535));
  endfunction

  function automatic int fit_angle(input int a);
    if (a > 32767) return 32767;
    if (a < -32768) return -32768;
    return a;
  endfunction

  // Mostly a slow walk near the setpoint at short dt, then noise and edge values
  task automatic send_random();
    int pick, step;
    logic signed [ANGLE_W-1:0] ang;
    logic [DT_W-1:0] dt;
    pick = $urandom_range(99);
    if (pick < 55) begin
      step = $urandom_range(0, 400);
      walk_angle = fit_angle(walk_angle + step - 200);
      if (walk_angle > cur_target + 3000 || walk_angle < cur_target - 3000)
        walk_angle = cur_target;
      ang = walk_angle[ANGLE_W-1:0];
      dt = DT_W'($urandom_range(1, 40));
    end else if (pick < 70) begin
      ang = ANGLE_W'($urandom);
      dt = DT_W'($urandom);
    end else if (pick < 80) begin
      ang = ANGLE_W'($urandom);
      dt = '0;
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0: ang = {1'b1, {(ANGLE_W-1){1'b0}}};
        1: ang = {1'b0, {(ANGLE_W-1){1'b1}}};
        2: ang = '0;
        default: ang = '1;
      endcase
      case ($urandom_range(2))
        0: dt = DT_W'(1);
        1: dt = '1;
        default: dt = DT_W'(1000);
      endcase
    end else begin
      step = $urandom_range(0, 8000);
      ang = ANGLE_W'(fit_angle(cur_target + step - 4000));
      dt = DT_W'($urandom_range(1, 2000));
    end
    send_sample(ang, dt);
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_idling(35, 74);

    // Power-on registers: all gains zero
    send_sample(16'sh7FFF, 16'd1);
    send_sample(16'sh8000, 16'hFFFF);

    // Full gains, deadband off: zero dt, extreme angles and dt
    load_regs(0, 65535, 65535, 65535, 8388607, 0);
    send_sample(16'sh8000, 16'd0);
    send_sample(16'sh7FFF, 16'd1);
    send_sample(16'sh8000, 16'd1);
    send_sample(16'sh0000, 16'hFFFF);
    send_sample(16'sh7FFF, 16'hFFFF);
    send_sample(16'sh0000, 16'd0);

    // Proportional only: deadband edge on both signs, duty clamp
    load_regs(0, 65535, 0, 0, 8388607, 10);
    send_sample(-16'sd160, 16'd1);
    send_sample(-16'sd161, 16'd1);
    send_sample(16'sd161, 16'd1);
    send_sample(16'sd160, 16'd1);
    send_sample(-16'sd4096, 16'd1);
    send_sample(-16'sd4112, 16'd1);
    send_sample(16'sh8000, 16'd1);

    // Integral only: charge it, then lower the limit under the stored value
    load_regs(0, 0, 65535, 0, 8388607, 0);
    send_sample(16'sh8000, 16'hFFFF);
    send_sample(16'sh8000, 16'hFFFF);
    load_regs(0, 0, 65535, 0, 1000, 0);
    send_sample(16'sh0000, 16'd1);
    send_sample(16'sh7FFF, 16'hFFFF);
    load_regs(0, 0, 65535, 0, 0, 0);
    send_sample(16'sh8000, 16'd1);

    // Random phases, each under its own register set
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) set_idling(74, 35);
      if (ph == 6) set_idling(0, 0);
      case (ph)
        0: load_regs(0, 65535, 65535, 65535, 8388607, 0);
        1: load_regs(-32768, pick_gain(), pick_gain(), pick_gain(), 0, 255);
        2: load_regs(32767, pick_gain(), 0, pick_gain(),
                     longint'($urandom_range(0, 5000)), longint'($urandom_range(0, 255)));
        default: load_regs(longint'($signed(16'($urandom))), pick_gain(), pick_gain(),
                           pick_gain(),
                           ($urandom_range(1) == 0) ? longint'($urandom_range(0, 8388607))
                                                    : longint'($urandom_range(0, 20000)),
                           ($urandom_range(1) == 0) ? longint'($urandom_range(0, 255))
                                                    : longint'($urandom_range(0, 20)));
      endcase
      // long output stall while samples keep coming
      if (ph == 6) want_hold <= 1'b1;
      repeat (PHASE_ITEMS) send_random();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run: %0d samples, %0d results checked, %0d register loads, %0d-cycle output hold",
             book.n_samples, book.n_checked, n_loads, HOLD_CYCLES);
    $display("Hit: %0d zero dt, %0d deadband, %0d integral clamp, %0d drive sat, %0d full duty",
             book.n_zero_dt, book.n_dead, book.n_iclamp, book.n_sat, book.n_duty_top);
    if (book.n_bad == 0 && book.drive_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", book.n_bad, book.drive_due.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/pbd_pkg.sv
hdl/pbd_div.sv
hdl/pbd_mac.sv
hdl/pid_balance_drive.sv
dv/tb_top.sv
